/* rtl/punctuator_tokenizer_unit_macros.svh */
// Assertion macros shared by the tokenizer modules.
`ifndef PUNCTUATOR_TOKENIZER_UNIT_MACROS_SVH
`define PUNCTUATOR_TOKENIZER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PTOK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");
// Next-cycle implication, disabled during reset.
`define PTOK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");
`else
`define PTOK_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define PTOK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/ptok_pkg.sv */
package ptok_pkg;

   // Kind of an emitted token.
   typedef enum logic [1:0] {
      KIND_SINGLE   = 2'd0,
      KIND_COMPOUND = 2'd1,
      KIND_UNKNOWN  = 2'd2,
      KIND_END      = 2'd3
   } kind_type;

   // One result token.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
   } token_type;

   // Most tokens a single character can cause.
   localparam int unsigned MaxTokens = 3;

   // All tokens caused by one input transaction, first token at index 0.
   typedef struct packed {
      logic [1:0]                      count;
      token_type [MaxTokens-1:0]       tok;
   } step_type;

endpackage

/* rtl/ptok_ifs.sv */
// Character input channel.
interface ptok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_input;

   modport source (output valid, output ch, output end_of_input, input ready);
   modport sink (input valid, input ch, input end_of_input, output ready);
endinterface

// Token result channel.
interface ptok_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] token_kind;
   logic [7:0] token_value;
   logic       last_of_run;

   modport source (output valid, output token_kind, output token_value,
                   output last_of_run, input ready);
   modport sink (input valid, input token_kind, input token_value,
                 input last_of_run, output ready);
endinterface

/* rtl/punctuator_tokenizer_unit.sv */
// The first token of a character is offered in the cycle after its transaction is accepted.
// Throughput: one character per cycle while each causes at most one token and the
// result port is ready; a character that causes more (up to three) holds the single
// result port until its last token is taken. One that causes no token takes no result
// slot, but it still waits while tokens of an earlier character are being handed out.
// Reset (synchronous, active high) clears the held operator and drops buffered tokens.
`include "punctuator_tokenizer_unit_macros.svh"

module punctuator_tokenizer_unit (
   input  logic       clock,
   input  logic       reset,
   ptok_req_if.sink   req_chan,
   ptok_rsp_if.source rsp_chan
);

   ptok_pkg::step_type step;
   logic               accept;
   logic               can_take;

   assign req_chan.ready = can_take;
   assign accept         = req_chan.valid && can_take;

   // Tokenizing logic and held operator state.
   ptok_lexer u_lexer (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .ch           (req_chan.ch),
      .end_of_input (req_chan.end_of_input),
      .step         (step)
   );

   // Result register that hands out one token per cycle while the sink is ready.
   ptok_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .step     (step),
      .can_take (can_take),
      .rsp_chan (rsp_chan)
   );

endmodule

/* rtl/ptok_lexer.sv */
`include "punctuator_tokenizer_unit_macros.svh"

module ptok_lexer (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         ch,
   input  logic               end_of_input,
   output ptok_pkg::step_type step
);

   // Character codes.
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LT    = "<";
   localparam logic [7:0] CH_GT    = ">";
   localparam logic [7:0] CH_DOT   = ".";
   localparam logic [7:0] CH_MINUS = "-";
   localparam logic [7:0] CH_EQ    = "=";

   // Compound operator codes.
   localparam logic [7:0] CODE_INC    = 8'd0;
   localparam logic [7:0] CODE_DEC    = 8'd1;
   localparam logic [7:0] CODE_LAND   = 8'd2;
   localparam logic [7:0] CODE_LOR    = 8'd3;
   localparam logic [7:0] CODE_EQ     = 8'd4;
   localparam logic [7:0] CODE_SHL    = 8'd5;
   localparam logic [7:0] CODE_SHR    = 8'd6;
   localparam logic [7:0] CODE_ELLIP  = 8'd7;
   localparam logic [7:0] CODE_SHLEQ  = 8'd8;
   localparam logic [7:0] CODE_SHREQ  = 8'd9;
   localparam logic [7:0] CODE_ARROW  = 8'd10;
   localparam logic [7:0] CODE_ADDEQ  = 8'd11;
   localparam logic [7:0] CODE_SUBEQ  = 8'd12;
   localparam logic [7:0] CODE_MULEQ  = 8'd13;
   localparam logic [7:0] CODE_DIVEQ  = 8'd14;
   localparam logic [7:0] CODE_MODEQ  = 8'd15;
   localparam logic [7:0] CODE_ANDEQ  = 8'd16;
   localparam logic [7:0] CODE_OREQ   = 8'd17;
   localparam logic [7:0] CODE_XOREQ  = 8'd18;
   localparam logic [7:0] CODE_LE     = 8'd19;
   localparam logic [7:0] CODE_GE     = 8'd20;
   localparam logic [7:0] CODE_NE     = 8'd21;

   function automatic logic is_ws(input logic [7:0] c);
      case (c) inside
         CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_VT: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic is_single(input logic [7:0] c);
      case (c) inside
         "(", ")", "[", "]", "{", "}", "@", "$", "~", "?", ":", ";", ",": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic logic is_holdable(input logic [7:0] c);
      case (c) inside
         "+", "-", "&", "|", "^", "<", ">", ".", "!", "*", "/", "%", "=": return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   // Code of the "c=" form; bit 8 is set when the form exists.
   function automatic logic [8:0] assign_code(input logic [7:0] c);
      case (c)
         "+": return {1'b1, CODE_ADDEQ};
         "-": return {1'b1, CODE_SUBEQ};
         "*": return {1'b1, CODE_MULEQ};
         "/": return {1'b1, CODE_DIVEQ};
         "%": return {1'b1, CODE_MODEQ};
         "&": return {1'b1, CODE_ANDEQ};
         "|": return {1'b1, CODE_OREQ};
         "^": return {1'b1, CODE_XOREQ};
         "<": return {1'b1, CODE_LE};
         ">": return {1'b1, CODE_GE};
         "!": return {1'b1, CODE_NE};
         default: return 9'd0;
      endcase
   endfunction

   // Code of a doubled character that completes at once; bit 8 flags it.
   function automatic logic [8:0] double_code(input logic [7:0] c);
      case (c)
         "+": return {1'b1, CODE_INC};
         "-": return {1'b1, CODE_DEC};
         "&": return {1'b1, CODE_LAND};
         "|": return {1'b1, CODE_LOR};
         "=": return {1'b1, CODE_EQ};
         default: return 9'd0;
      endcase
   endfunction

   logic [7:0] held_char_ff;
   logic [7:0] held_char_in;
   logic [1:0] held_count_ff;
   logic [1:0] held_count_in;

   logic [1:0]          hc;
   logic                do_flush;
   logic                do_fresh;
   logic                comp_hit;
   logic [7:0]          comp_code;
   logic [8:0]          dbl;
   logic [8:0]          asg;
   logic [1:0]          cnt;
   ptok_pkg::step_type  step_c;

   // Decide what this character does against the held operator.
   always_comb begin
      hc            = (held_count_ff == 2'd3) ? 2'd0 : held_count_ff;
      dbl           = double_code(held_char_ff);
      asg           = assign_code(held_char_ff);
      do_flush      = 1'b0;
      do_fresh      = 1'b0;
      comp_hit      = 1'b0;
      comp_code     = 8'd0;
      held_char_in  = held_char_ff;
      held_count_in = 2'd0;

      if (end_of_input) begin
         do_flush = 1'b1;
      end else if (hc == 2'd0) begin
         do_fresh = 1'b1;
      end else if (hc == 2'd1) begin
         if (ch == held_char_ff && dbl[8]) begin
            comp_hit  = 1'b1;
            comp_code = dbl[7:0];
         end else if (ch == held_char_ff && (held_char_ff == CH_LT ||
                      held_char_ff == CH_GT || held_char_ff == CH_DOT)) begin
            held_count_in = 2'd2;
         end else if (held_char_ff == CH_MINUS && ch == CH_GT) begin
            comp_hit  = 1'b1;
            comp_code = CODE_ARROW;
         end else if (ch == CH_EQ && asg[8]) begin
            comp_hit  = 1'b1;
            comp_code = asg[7:0];
         end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
         end
      end else begin
         if (held_char_ff == CH_LT && ch == CH_EQ) begin
            comp_hit  = 1'b1;
            comp_code = CODE_SHLEQ;
         end else if (held_char_ff == CH_GT && ch == CH_EQ) begin
            comp_hit  = 1'b1;
            comp_code = CODE_SHREQ;
         end else if (held_char_ff == CH_DOT && ch == CH_DOT) begin
            comp_hit  = 1'b1;
            comp_code = CODE_ELLIP;
         end else begin
            do_flush = 1'b1;
            do_fresh = 1'b1;
         end
      end

      // A fresh holdable character becomes the new held operator.
      if (do_fresh && !is_ws(ch) && !is_single(ch) && is_holdable(ch)) begin
         held_char_in  = ch;
         held_count_in = 2'd1;
      end
   end

   // Collect the tokens in emission order: flush, compound, fresh, end.
   always_comb begin
      step_c = '0;
      cnt    = 2'd0;
      if (do_flush) begin
         if (hc == 2'd1) begin
            step_c.tok[cnt] = '{ptok_pkg::KIND_SINGLE, held_char_ff};
            cnt = cnt + 2'd1;
         end else if (hc == 2'd2) begin
            if (held_char_ff == CH_LT) begin
               step_c.tok[cnt] = '{ptok_pkg::KIND_COMPOUND, CODE_SHL};
               cnt = cnt + 2'd1;
            end else if (held_char_ff == CH_GT) begin
               step_c.tok[cnt] = '{ptok_pkg::KIND_COMPOUND, CODE_SHR};
               cnt = cnt + 2'd1;
            end else begin
               step_c.tok[cnt] = '{ptok_pkg::KIND_SINGLE, held_char_ff};
               cnt = cnt + 2'd1;
               step_c.tok[cnt] = '{ptok_pkg::KIND_SINGLE, held_char_ff};
               cnt = cnt + 2'd1;
            end
         end
      end
      if (comp_hit) begin
         step_c.tok[cnt] = '{ptok_pkg::KIND_COMPOUND, comp_code};
         cnt = cnt + 2'd1;
      end
      if (do_fresh && !is_ws(ch)) begin
         if (is_single(ch)) begin
            step_c.tok[cnt] = '{ptok_pkg::KIND_SINGLE, ch};
            cnt = cnt + 2'd1;
         end else if (!is_holdable(ch)) begin
            step_c.tok[cnt] = '{ptok_pkg::KIND_UNKNOWN, ch};
            cnt = cnt + 2'd1;
         end
      end
      if (end_of_input) begin
         step_c.tok[cnt] = '{ptok_pkg::KIND_END, 8'd0};
         cnt = cnt + 2'd1;
      end
      step_c.count = cnt;
   end

   assign step = step_c;

   // Held operator state advances on every accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_char_ff  <= 8'd0;
         held_count_ff <= 2'd0;
      end else if (accept) begin
         held_char_ff  <= held_char_in;
         held_count_ff <= held_count_in;
      end
   end

   `PTOK_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, held_count_ff != 2'd3)
   `PTOK_ASSERT_IMPLY(a_double_hold, clock, reset, held_count_ff == 2'd2, held_char_ff == CH_LT || held_char_ff == CH_GT || held_char_ff == CH_DOT)
   `PTOK_ASSERT_NEXT(a_eoi_clears, clock, reset, accept && end_of_input, held_count_ff == 2'd0)

endmodule

/* rtl/ptok_queue.sv */
`include "punctuator_tokenizer_unit_macros.svh"

module ptok_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  ptok_pkg::step_type  step,
   output logic                can_take,
   ptok_rsp_if.source          rsp_chan
);

   ptok_pkg::token_type tok_ff [ptok_pkg::MaxTokens];
   logic [1:0]          count_ff;
   logic [1:0]          count_in;
   logic [1:0]          idx_ff;
   logic [1:0]          idx_in;
   logic                last;
   logic                pop;

   assign last = (idx_ff == count_ff - 2'd1);
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   // A new transaction fits once the buffer is empty or hands out its last token now.
   assign can_take = (count_ff == 2'd0) || (last && rsp_chan.ready);

   assign rsp_chan.valid       = (count_ff != 2'd0);
   assign rsp_chan.token_kind  = tok_ff[idx_ff].kind;
   assign rsp_chan.token_value = tok_ff[idx_ff].value;
   assign rsp_chan.last_of_run = last;

   // Read pointer and fill count.
   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      if (load) begin
         count_in = step.count;
         idx_in   = 2'd0;
      end else if (pop) begin
         if (last) begin
            count_in = 2'd0;
            idx_in   = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         idx_ff   <= 2'd0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   // Token payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < ptok_pkg::MaxTokens; i++) begin
            tok_ff[i] <= step.tok[i];
         end
      end
   end

   `PTOK_ASSERT_IMPLY(a_idx_in_range, clock, reset, count_ff != 2'd0, idx_ff < count_ff)
   `PTOK_ASSERT_NEXT(a_load_shows, clock, reset, load && step.count != 2'd0, rsp_chan.valid && idx_ff == 2'd0)

endmodule
